// File: design/obst_pkg.sv
// Shared types, constants and the saturating adder for the optimal BST cost table.
package obst_pkg;

    localparam int WEIGHT_W = 16;
    localparam int COST_W   = 24;
    localparam int IDX_W    = 4;

    localparam logic [COST_W-1:0] COST_INF = 24'hFFFFFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIAG0,
        ST_SPAN_INIT,
        ST_READ,
        ST_CMP,
        ST_FIN
    } state_t;

    // Sum of two costs, clipped at the ceiling.
    function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                  input logic [COST_W-1:0] b);
        logic [COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, COST_INF}) ? COST_INF : s[COST_W-1:0];
    endfunction

endpackage

// File: design/obst_ram.sv
// Generic RAM with one write port and two registered read ports.
module obst_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 72
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// File: design/optimal_bst_cost_table.sv
// Optimal binary search tree cost table: weight loading, table fill sequencer and result port.
//
// Keys are loaded one beat at a time: a beat is taken at a rising edge with start high and
// busy low, and each beat stores its weight (beats beyond MAX_KEYS are dropped). A load beat
// leaves busy low. The beat with last_key high also starts the table fill for the n keys held,
// and busy stays high until the fill is over.
// The fill emits one result per span in diagonal order, each shown for one cycle with valid
// high: first the single-key spans, one per cycle, then the longer spans, ending with span
// 1..n, which carries final_entry. A span of length L runs SPAN_INIT, then one READ and CMP
// pair per candidate root, then FIN, paced by the one shared saturating adder and the cost
// RAM with two read ports, which is read once per candidate root.
// The receiver cannot stall; results are simply strobed out.
// Reset returns the sequencer to idle and empties the key count. The cost RAM needs no clearing:
// every entry read during a fill was written earlier in the same fill, and empty subtrees
// are taken as zero without a read.
module optimal_bst_cost_table #(
    parameter int MAX_KEYS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [obst_pkg::WEIGHT_W-1:0] weight,
    input  logic                          last_key,
    output logic                          valid,
    output logic [obst_pkg::IDX_W-1:0]    span_first,
    output logic [obst_pkg::IDX_W-1:0]    span_final,
    output logic [obst_pkg::IDX_W-1:0]    best_root,
    output logic [obst_pkg::COST_W-1:0]   span_cost,
    output logic                          final_entry
);

    localparam int DIM    = MAX_KEYS + 1;
    localparam int DEPTH  = MAX_KEYS * DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int WA_W   = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam logic [obst_pkg::IDX_W-1:0] MAX_IDX = obst_pkg::IDX_W'(MAX_KEYS);
    localparam logic [7:0] DIM8 = 8'(DIM);

    // Cost RAM address of span i..j, with i and j both from 1 to MAX_KEYS.
    function automatic logic [ADDR_W-1:0] cost_addr(input logic [obst_pkg::IDX_W-1:0] i,
                                                     input logic [obst_pkg::IDX_W-1:0] j);
        logic [7:0] row;
        logic [7:0] flat;
        row  = {4'b0, i} - 8'd1;
        flat = row * DIM8 + {4'b0, j};
        return flat[ADDR_W-1:0];
    endfunction

    obst_pkg::state_t state_reg, state_next;

    logic [obst_pkg::WEIGHT_W-1:0] weight_mem [MAX_KEYS];

    logic [obst_pkg::IDX_W-1:0]  key_count_reg, key_count_next;
    logic [obst_pkg::IDX_W-1:0]  n_reg, n_next;
    logic [obst_pkg::IDX_W-1:0]  d_reg, d_next;
    logic [obst_pkg::IDX_W-1:0]  i_reg, i_next;
    logic [obst_pkg::IDX_W-1:0]  k_reg, k_next;
    logic [obst_pkg::COST_W-1:0] best_reg, best_next;
    logic [obst_pkg::IDX_W-1:0]  root_reg, root_next;
    logic [obst_pkg::COST_W-1:0] wsum_reg, wsum_next;

    logic                          valid_reg, valid_next;
    logic [obst_pkg::IDX_W-1:0]    first_reg, first_next;
    logic [obst_pkg::IDX_W-1:0]    final_reg, final_next;
    logic [obst_pkg::IDX_W-1:0]    broot_reg, broot_next;
    logic [obst_pkg::COST_W-1:0]   cost_reg, cost_next;
    logic                          fentry_reg, fentry_next;

    logic [obst_pkg::IDX_W-1:0]  j_cur;
    logic [obst_pkg::IDX_W-1:0]  k_dec;
    logic [obst_pkg::IDX_W-1:0]  k_inc;
    logic [obst_pkg::IDX_W-1:0]  i_dec;
    logic                        accept;
    logic                        store_en;
    logic [WA_W-1:0]             store_idx;
    logic [obst_pkg::WEIGHT_W-1:0] wk;
    logic [obst_pkg::WEIGHT_W-1:0] wi;

    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_waddr;
    logic [obst_pkg::COST_W-1:0] ram_wdata;
    logic [ADDR_W-1:0]           ram_raddr_a;
    logic [ADDR_W-1:0]           ram_raddr_b;
    logic [obst_pkg::COST_W-1:0] ram_rdata_a;
    logic [obst_pkg::COST_W-1:0] ram_rdata_b;

    logic [obst_pkg::COST_W-1:0] add_a;
    logic [obst_pkg::COST_W-1:0] add_b;
    logic [obst_pkg::COST_W-1:0] add_sum;

    assign busy   = (state_reg != obst_pkg::ST_IDLE);
    assign accept = start && !busy;
    assign j_cur  = i_reg + d_reg;
    assign k_dec  = k_reg - 4'd1;
    assign k_inc  = k_reg + 4'd1;
    assign i_dec  = i_reg - 4'd1;

    assign store_en  = accept && (key_count_reg < MAX_IDX);
    assign store_idx = key_count_reg[WA_W-1:0];
    assign wk        = weight_mem[k_dec[WA_W-1:0]];
    assign wi        = weight_mem[i_dec[WA_W-1:0]];

    always_ff @(posedge clk)
    begin
        if (store_en)
        begin
            weight_mem[store_idx] <= weight;
        end
    end

    obst_ram #(
        .WIDTH (obst_pkg::COST_W),
        .DEPTH (DEPTH)
    ) u_cost_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    // The one shared adder: weight sum while reading, candidate in compare, span total at the end.
    always_comb
    begin
        add_a = '0;
        add_b = '0;
        unique case (state_reg)
            obst_pkg::ST_READ:
            begin
                add_a = wsum_reg;
                add_b = {8'b0, wk};
            end
            obst_pkg::ST_CMP:
            begin
                add_a = (k_reg == i_reg) ? '0 : ram_rdata_a;
                add_b = (k_reg == j_cur) ? '0 : ram_rdata_b;
            end
            obst_pkg::ST_FIN:
            begin
                add_a = best_reg;
                add_b = wsum_reg;
            end
            default:
            begin
                add_a = '0;
                add_b = '0;
            end
        endcase
    end

    assign add_sum = obst_pkg::sat_add(add_a, add_b);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            obst_pkg::ST_IDLE:
            begin
                if (accept && last_key)
                begin
                    state_next = obst_pkg::ST_DIAG0;
                end
            end
            obst_pkg::ST_DIAG0:
            begin
                if (i_reg == n_reg)
                begin
                    state_next = (n_reg == 4'd1) ? obst_pkg::ST_IDLE : obst_pkg::ST_SPAN_INIT;
                end
            end
            obst_pkg::ST_SPAN_INIT:
            begin
                state_next = obst_pkg::ST_READ;
            end
            obst_pkg::ST_READ:
            begin
                state_next = obst_pkg::ST_CMP;
            end
            obst_pkg::ST_CMP:
            begin
                state_next = (k_reg == j_cur) ? obst_pkg::ST_FIN : obst_pkg::ST_READ;
            end
            obst_pkg::ST_FIN:
            begin
                if (j_cur == n_reg && d_reg + 4'd1 == n_reg)
                begin
                    state_next = obst_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = obst_pkg::ST_SPAN_INIT;
                end
            end
            default:
            begin
                state_next = obst_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and result port.
    always_comb
    begin
        key_count_next = key_count_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        i_next         = i_reg;
        k_next         = k_reg;
        best_next      = best_reg;
        root_next      = root_reg;
        wsum_next      = wsum_reg;
        valid_next     = 1'b0;
        first_next     = first_reg;
        final_next     = final_reg;
        broot_next     = broot_reg;
        cost_next      = cost_reg;
        fentry_next    = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = cost_addr(i_reg, j_cur);
        ram_wdata      = add_sum;
        ram_raddr_a    = '0;
        ram_raddr_b    = '0;
        unique case (state_reg)
            obst_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (last_key)
                    begin
                        n_next         = store_en ? key_count_reg + 4'd1 : key_count_reg;
                        key_count_next = '0;
                        i_next         = 4'd1;
                        d_next         = '0;
                    end
                    else if (store_en)
                    begin
                        key_count_next = key_count_reg + 4'd1;
                    end
                end
            end
            obst_pkg::ST_DIAG0:
            begin
                ram_we      = 1'b1;
                ram_waddr   = cost_addr(i_reg, i_reg);
                ram_wdata   = {8'b0, wi};
                valid_next  = 1'b1;
                first_next  = i_reg;
                final_next  = i_reg;
                broot_next  = i_reg;
                cost_next   = {8'b0, wi};
                fentry_next = (i_reg == 4'd1) && (n_reg == 4'd1);
                if (i_reg == n_reg)
                begin
                    i_next = 4'd1;
                    d_next = 4'd1;
                end
                else
                begin
                    i_next = i_reg + 4'd1;
                end
            end
            obst_pkg::ST_SPAN_INIT:
            begin
                k_next    = i_reg;
                best_next = obst_pkg::COST_INF;
                root_next = '0;
                wsum_next = '0;
            end
            obst_pkg::ST_READ:
            begin
                wsum_next   = add_sum;
                ram_raddr_a = (k_reg == i_reg) ? '0 : cost_addr(i_reg, k_dec);
                ram_raddr_b = (k_reg == j_cur) ? '0 : cost_addr(k_inc, j_cur);
            end
            obst_pkg::ST_CMP:
            begin
                if (add_sum < best_reg)
                begin
                    best_next = add_sum;
                    root_next = k_reg;
                end
                k_next = k_inc;
            end
            obst_pkg::ST_FIN:
            begin
                ram_we      = 1'b1;
                valid_next  = 1'b1;
                first_next  = i_reg;
                final_next  = j_cur;
                broot_next  = root_reg;
                cost_next   = add_sum;
                fentry_next = (i_reg == 4'd1) && (j_cur == n_reg);
                if (j_cur == n_reg)
                begin
                    i_next = 4'd1;
                    d_next = d_reg + 4'd1;
                end
                else
                begin
                    i_next = i_reg + 4'd1;
                end
            end
            default:
            begin
                valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= obst_pkg::ST_IDLE;
            key_count_reg <= '0;
            valid_reg     <= 1'b0;
            fentry_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            key_count_reg <= key_count_next;
            valid_reg     <= valid_next;
            fentry_reg    <= fentry_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        d_reg     <= d_next;
        i_reg     <= i_next;
        k_reg     <= k_next;
        best_reg  <= best_next;
        root_reg  <= root_next;
        wsum_reg  <= wsum_next;
        first_reg <= first_next;
        final_reg <= final_next;
        broot_reg <= broot_next;
        cost_reg  <= cost_next;
    end

    assign valid       = valid_reg;
    assign span_first  = first_reg;
    assign span_final  = final_reg;
    assign best_root   = broot_reg;
    assign span_cost   = cost_reg;
    assign final_entry = fentry_reg;

    // A result is only ever produced by a fill that was running in the cycle before.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> $past(busy))
    else $error("result beat without a running fill");

    // The overall optimum is the last beat of a fill, so the sequencer is idle by then.
    assert property (@(posedge clk) disable iff (!rst_n)
        final_entry |-> valid && !busy)
    else $error("final entry seen while the fill is still running");

    // Spans are never reversed and a real cost always has a root inside its span.
    assert property (@(posedge clk) disable iff (!rst_n)
        valid && span_cost != obst_pkg::COST_INF |->
            span_first <= span_final && best_root >= span_first && best_root <= span_final)
    else $error("root outside its span");

    // The candidate root stays within the span under test.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == obst_pkg::ST_CMP |-> k_reg >= i_reg && k_reg <= j_cur)
    else $error("candidate root out of range");

endmodule
